>>> rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Default capacity and read-out bound
  localparam int PLS_CAPACITY = 16;
  localparam int RESULT_LIMIT = 16;

  // Element width, and index width covering the largest allowed capacity
  localparam int VAL_W = 32;
  localparam int IDX_W = 10;

  // Request codes
  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_SEARCH    = 3'd6,
    REQ_READ      = 3'd7
  } req_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_ELEMENT  = 3'd6
  } status_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] k;   // 0-based slot the insert or delete acts on
  } cell_cmd_t;

endpackage

>>> rtl/core/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered store of signed 32-bit values with positional insert and delete,
// search and in-order read-out, built as a ring of cells.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, head in cell 0. Inserts and
// deletes shift the cells from the target slot on in a single update: the
// request is accepted in S_IDLE, then S_EXEC executes it and loads the result.
// Search and read-out rotate the ring one cell per cycle past the head for a
// full turn, which restores the order; a read-out pauses the rotation while
// its next result waits on m_tready, and a search then reports in S_REPLY.
// Requests on an empty list answer from S_EXEC without a scan. A new request is
// taken only after the previous one has finished; a finished result may
// still sit in the output register while the next request is accepted.
module positional_list_store_top #(
  parameter int CAPACITY = pls_pkg::PLS_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // req_type[2:0], value[34:3], position[42:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[2:0], element[34:3],
                                 // element_index[39:35], count[44:40]
  output logic        m_tlast
);
  import pls_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPLY
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  req_t               req_type;
  logic [VAL_W-1:0]   req_value;
  logic [7:0]         req_pos;
  logic [SW-1:0]      step;
  logic               found;

  logic [VAL_W-1:0]   cell_data [CAPACITY];
  cell_cmd_t          cell_cmd;

  logic               slot_free;
  logic               is_empty;
  logic               is_full;
  logic               ins_ok;
  logic               del_ok;
  logic               exec_scan;
  status_t            exec_status;
  logic [CW-1:0]      count_next;
  logic               step_lt_n;
  logic               emit_step;
  logic               scan_adv;
  logic               scan_end;
  logic               step_last;
  logic               out_load;

  assign s_tready  = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(CAPACITY));

  // Position checks
  assign ins_ok = is_empty ? (req_pos == 8'd1)
                           : ((req_pos != 8'd0) && (int'(req_pos) <= int'(count)));
  assign del_ok = (req_pos != 8'd0) && (int'(req_pos) <= int'(count));

  // Scan bookkeeping
  assign step_lt_n = int'(step) < int'(count);
  assign emit_step = (req_type == REQ_READ) && step_lt_n && (int'(step) < RESULT_LIMIT);
  assign step_last = (int'(step) + 1 == int'(count)) || (int'(step) + 1 == RESULT_LIMIT);
  assign scan_adv  = !emit_step || slot_free;
  assign scan_end  = (step == SW'(CAPACITY - 1));

  // Output register gets a new result this cycle
  assign out_load = ((state == S_EXEC) && !exec_scan && slot_free) ||
                    ((state == S_SCAN) && scan_adv && emit_step) ||
                    ((state == S_REPLY) && slot_free);

  // Request decode and cell command
  always_comb begin
    cell_cmd    = '{op: CELL_HOLD, k: '0};
    exec_status = ST_DONE;
    exec_scan   = 1'b0;
    count_next  = count;
    case (state)
      S_EXEC: begin
        case (req_type)
          REQ_INS_FRONT: begin
            if (is_full) begin
              exec_status = ST_FULL;
            end else begin
              cell_cmd   = '{op: CELL_INSERT, k: '0};
              count_next = count + CW'(1);
            end
          end
          REQ_INS_END: begin
            if (is_full) begin
              exec_status = ST_FULL;
            end else begin
              cell_cmd   = '{op: CELL_INSERT, k: IDX_W'(count)};
              count_next = count + CW'(1);
            end
          end
          REQ_INS_POS: begin
            if (!ins_ok) begin
              exec_status = ST_BADPOS;
            end else if (is_full) begin
              exec_status = ST_FULL;
            end else begin
              cell_cmd   = '{op: CELL_INSERT, k: IDX_W'(int'(req_pos) - 1)};
              count_next = count + CW'(1);
            end
          end
          REQ_DEL_FRONT: begin
            if (is_empty) begin
              exec_status = ST_EMPTY;
            end else begin
              cell_cmd   = '{op: CELL_DELETE, k: '0};
              count_next = count - CW'(1);
            end
          end
          REQ_DEL_END: begin
            if (is_empty) begin
              exec_status = ST_EMPTY;
            end else begin
              count_next = count - CW'(1);
            end
          end
          REQ_DEL_POS: begin
            if (is_empty) begin
              exec_status = ST_EMPTY;
            end else if (!del_ok) begin
              exec_status = ST_BADPOS;
            end else begin
              cell_cmd   = '{op: CELL_DELETE, k: IDX_W'(int'(req_pos) - 1)};
              count_next = count - CW'(1);
            end
          end
          default: begin
            // search and read-out
            if (is_empty) begin
              exec_status = ST_EMPTY;
            end else begin
              exec_scan = 1'b1;
            end
          end
        endcase
        // nothing changes until the result can be loaded
        if (!slot_free && !exec_scan) begin
          cell_cmd   = '{op: CELL_HOLD, k: '0};
          count_next = count;
        end
      end
      S_SCAN: begin
        if (scan_adv) begin
          cell_cmd = '{op: CELL_ROTATE, k: '0};
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      step     <= '0;
      found    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_type  <= req_t'(s_tdata[2:0]);
            req_value <= s_tdata[34:3];
            req_pos   <= s_tdata[42:35];
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_scan) begin
            step  <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else if (slot_free) begin
            count    <= count_next;
            m_tlast  <= 1'b1;
            m_tdata  <= {3'd0, 5'(count_next), 5'd0, {VAL_W{1'b0}}, exec_status};
            state    <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_adv) begin
            if (emit_step) begin
              m_tlast  <= step_last;
              m_tdata  <= {3'd0, 5'(count), 5'(int'(step) + 1), cell_data[0], ST_ELEMENT};
            end
            if ((req_type == REQ_SEARCH) && step_lt_n && (cell_data[0] == req_value)) begin
              found <= 1'b1;
            end
            if (scan_end) begin
              state <= (req_type == REQ_SEARCH) ? S_REPLY : S_IDLE;
            end else begin
              step <= step + SW'(1);
            end
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            m_tlast  <= 1'b1;
            m_tdata  <= {3'd0, 5'(count), 5'd0, {VAL_W{1'b0}},
                         found ? ST_FOUND : ST_NOTFOUND};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Ring of cells: head in cell 0, last cell wraps to the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_data;
    if (i == 0) begin : g_head
      assign left_data = cell_data[0];
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end
    pls_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .ins_value  (req_value),
      .left_data  (left_data),
      .right_data (cell_data[(i + 1) % CAPACITY]),
      .data       (cell_data[i])
    );
  end

  // Checks
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("element count above capacity");

  a_count_exec_only : assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(count))
    else $error("element count changed outside execute");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while one is in flight");

  a_elem_index : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == ST_ELEMENT)) |-> (m_tdata[39:35] != 5'd0))
    else $error("read-out result without element index");

  a_elem_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] != ST_ELEMENT)) |-> (m_tdata[39:3] == '0))
    else $error("element fields set on a non read-out result");

endmodule

>>> rtl/core/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One storage cell of the list chain; takes its left or right neighbor,
// the new value, or holds, as the broadcast command says.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  pls_pkg::cell_cmd_t       cmd,
  input  logic [pls_pkg::VAL_W-1:0] ins_value,
  input  logic [pls_pkg::VAL_W-1:0] left_data,
  input  logic [pls_pkg::VAL_W-1:0] right_data,
  output logic [pls_pkg::VAL_W-1:0] data
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  // Shift toward the tail on insert, toward the head on delete and rotate
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > cmd.k) begin
          data <= left_data;
        end else if (MY_IDX == cmd.k) begin
          data <= ins_value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= cmd.k) begin
          data <= right_data;
        end
      end
      CELL_ROTATE: begin
        data <= right_data;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_store_top. Requests are sent on
// the slave stream and every result on the master stream is checked field
// by field against a shadow copy of the list kept in the bench. A short
// directed pass covers empty-list cases, bad positions and extreme values.
// A random pass then grows and shrinks the list so that it fills up, with
// random gaps on both streams, one long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;
  import pls_pkg::*;

  localparam int STORE_DEPTH = PLS_CAPACITY;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;
  localparam int HOLD_AFTER  = 40;

  typedef struct {
    req_t        op;
    logic [31:0] value;
    logic [7:0]  position;
    bit          drain;     // wait until all results are in before sending
  } list_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] element;
    logic [4:0]  elem_index;
    logic        last;
    logic [4:0]  count;
  } list_result_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // req_type[2:0], value[34:3], position[42:35]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // status[2:0], element[34:3],
                               // element_index[39:35], count[44:40]
  logic        m_tlast;

  list_req_t    req_queue[$];
  list_result_t expected_results[$];

  // Shadow of the list contents
  logic [31:0] shadow_cells[STORE_DEPTH];
  int          shadow_len = 0;

  // Length seen by the stimulus generator while it plans requests
  int          plan_len = 0;
  logic [31:0] value_pool[6];

  bit          failed = 1'b0;
  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  int          accepted_count = 0;
  int          cycle_count = 0;
  int          tx_gap = 0;
  bit          tx_burst = 1'b0;
  int          rx_stall = 0;
  bit          rx_burst = 1'b0;
  int          hold_cycles = 0;
  bit          hold_started = 1'b0;

  positional_list_store_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list update and result prediction
  // --------------------------------------------------------------------------
  function automatic void push_result(status_t st, logic [31:0] elem, int idx,
                                      bit lst);
    list_result_t r;
    r.status     = st;
    r.element    = elem;
    r.elem_index = idx[4:0];
    r.last       = lst;
    r.count      = shadow_len[4:0];
    expected_results.push_back(r);
  endfunction

  task automatic apply_request(input req_t op, input logic [31:0] v,
                               input logic [7:0] p);
    int      n;
    int      k;
    int      i;
    int      m;
    bit      ok;
    status_t st;
    n  = shadow_len;
    st = ST_DONE;
    case (op)
      REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: begin
        ok = (op != REQ_INS_POS) || ((n == 0) ? (p == 1) : (p >= 1 && p <= n));
        if (!ok) begin
          st = ST_BADPOS;
        end else if (n >= STORE_DEPTH) begin
          st = ST_FULL;
        end else begin
          if (op == REQ_INS_FRONT) k = 0;
          else if (op == REQ_INS_END) k = n;
          else k = int'(p) - 1;
          for (i = n; i > k; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[k] = v;
          shadow_len++;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_POS: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else if (op == REQ_DEL_POS && (p < 1 || p > n)) begin
          st = ST_BADPOS;
        end else begin
          if (op == REQ_DEL_FRONT) k = 0;
          else if (op == REQ_DEL_END) k = n - 1;
          else k = int'(p) - 1;
          for (i = k; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      REQ_SEARCH: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          st = ST_NOTFOUND;
          for (i = 0; i < n; i++)
            if (shadow_cells[i] == v) st = ST_FOUND;
        end
      end
      default: begin
        // Read-out: one result per element, bounded by the result limit
        if (n == 0) begin
          push_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          m = (n > RESULT_LIMIT) ? RESULT_LIMIT : n;
          for (i = 0; i < m; i++)
            push_result(ST_ELEMENT, shadow_cells[i], i + 1, (i + 1 == m));
        end
        return;
      end
    endcase
    push_result(st, '0, 0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  task automatic queue_request(input req_t op, input logic [31:0] v,
                               input logic [7:0] p, input bit drain = 1'b0);
    list_req_t r;
    bit        ok;
    r.op       = op;
    r.value    = v;
    r.position = p;
    r.drain    = drain;
    req_queue.push_back(r);
    // Track the length so positions can be aimed at the valid range
    if (op inside {REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS}) begin
      ok = (op != REQ_INS_POS) ||
           ((plan_len == 0) ? (p == 1) : (p >= 1 && p <= plan_len));
      if (ok && plan_len < STORE_DEPTH) plan_len++;
    end else if (op inside {REQ_DEL_FRONT, REQ_DEL_END, REQ_DEL_POS}) begin
      if (plan_len > 0 && (op != REQ_DEL_POS || (p >= 1 && p <= plan_len)))
        plan_len--;
    end
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 4) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(1, (plan_len > 0) ? plan_len : 1));
    if (r == 7) return 8'(plan_len + 1);
    if (r == 8) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int   n;
    int   r;
    int   run_left;
    int   ins_pct;
    int   del_pct;
    mix_t mix;
    req_t op;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    for (n = 2; n < 6; n++) value_pool[n] = $urandom;

    // Directed: empty list first
    queue_request(REQ_READ,      32'd0, 8'd0);
    queue_request(REQ_SEARCH,    32'd5, 8'd0);
    queue_request(REQ_DEL_FRONT, 32'd0, 8'd0);
    queue_request(REQ_DEL_END,   32'd0, 8'd0);
    queue_request(REQ_DEL_POS,   32'd0, 8'd3);
    queue_request(REQ_INS_POS,   32'd9, 8'd0);
    queue_request(REQ_INS_POS,   32'd9, 8'd2);
    // Build a short list with extreme values
    queue_request(REQ_INS_POS,   32'h8000_0000, 8'd1);
    queue_request(REQ_INS_FRONT, 32'h7fff_ffff, 8'd0);
    queue_request(REQ_INS_END,   32'hffff_ffff, 8'd0);
    queue_request(REQ_INS_POS,   32'd7, 8'd4);      // length + 1 is rejected
    queue_request(REQ_INS_POS,   32'd7, 8'd255);
    queue_request(REQ_INS_POS,   32'd0, 8'd2);
    queue_request(REQ_SEARCH,    32'h8000_0000, 8'd0);
    queue_request(REQ_SEARCH,    32'd12345, 8'd0);
    queue_request(REQ_READ,      32'd0, 8'd0);
    // Positional deletes, bad and good, then drain to empty
    queue_request(REQ_DEL_POS,   32'd0, 8'd0);
    queue_request(REQ_DEL_POS,   32'd0, 8'd5);
    queue_request(REQ_DEL_POS,   32'd0, 8'd4);
    queue_request(REQ_DEL_POS,   32'd0, 8'd1);
    queue_request(REQ_DEL_FRONT, 32'd0, 8'd0);
    queue_request(REQ_DEL_END,   32'd0, 8'd0);
    queue_request(REQ_READ,      32'd0, 8'd0);

    // Random: runs that favor growth, shrinkage or a balance of both
    run_left = 0;
    mix      = MIX_GROW;
    for (n = 0; n < 87; n++) begin
      if (n == 0) begin
        mix      = MIX_GROW;
        run_left = 30;
      end else if (run_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 20);
      end
      run_left--;
      case (mix)
        MIX_GROW:   begin ins_pct = 75; del_pct = 5;  end
        MIX_SHRINK: begin ins_pct = 10; del_pct = 70; end
        default:    begin ins_pct = 40; del_pct = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = req_t'($urandom_range(0, 2));
      else if (r < ins_pct + del_pct) op = req_t'($urandom_range(3, 5));
      else if (r < ins_pct + del_pct + 10) op = REQ_SEARCH;
      else op = REQ_READ;
      queue_request(op, pick_value(), pick_position(), (n % 35) == 0);
    end

    // Reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all requests to go out and all results to come back
    while (req_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2 * STORE_DEPTH + 8) @(posedge clk);
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver: one offer per item, random gap after each transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    list_req_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (s_tvalid && !req_taken) begin
      // offer stays up until it is taken
    end else if (tx_gap != 0) begin
      s_tvalid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (req_queue.size() != 0 &&
                 !(req_queue[0].drain && expected_results.size() != 0)) begin
      item = req_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {5'b0, item.position, item.value, item.op};
      tx_gap   <= tx_burst ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 15) == 0) tx_burst <= !tx_burst;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Long output hold-off, started once partway through the run
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (!hold_started && accepted_count >= HOLD_AFTER) begin
      hold_cycles  <= LONG_HOLD;
      hold_started <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stall drawn after each transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (hold_cycles != 0) begin
      m_tready <= 1'b0;
    end else if (res_taken) begin
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0) rx_burst <= !rx_burst;
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_stall <= stall - 1;
      end
    end else if (m_tready) begin
      // still waiting for a result
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each request transfer, check each result transfer
  // --------------------------------------------------------------------------
  function automatic bit compare_field(string label, logic [31:0] want,
                                       logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h",
               $time, label, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    bit           bad;
    if (rst) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && (s_tready === 1'b1);
      res_taken <= (m_tvalid === 1'b1) && m_tready;
      if (s_tvalid && s_tready === 1'b1) begin
        accepted_count <= accepted_count + 1;
        apply_request(req_t'(s_tdata[2:0]), s_tdata[34:3], s_tdata[42:35]);
      end
      if (m_tvalid === 1'b1 && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual data %0h last %b",
                   $time, m_tdata, m_tlast);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          bad |= compare_field("status", 32'(want.status), 32'(m_tdata[2:0]));
          bad |= compare_field("element", want.element, m_tdata[34:3]);
          bad |= compare_field("element_index", 32'(want.elem_index),
                               32'(m_tdata[39:35]));
          bad |= compare_field("count", 32'(want.count), 32'(m_tdata[44:40]));
          bad |= compare_field("last", 32'(want.last), 32'(m_tlast));
          if (bad) failed = 1'b1;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/core/pls_pkg.sv
rtl/core/pls_cell.sv
rtl/core/positional_list_store_top.sv
sim/tb.sv
